FILE: rtl/pfn_pkg.sv
// shared types and codes for the polygon face normal block
package pfn_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_ZERO    = 2'd2,
    ST_TOOMANY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAC,
    OP_CHECK,
    OP_ABS,
    OP_SHIFT,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_DIV_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
    logic [1:0] comp;
    status_t    stat;
  } cmd_t;

  typedef struct packed {
    logic    take;
    logic    ge2;
    logic    last;
    status_t err;
    logic    m_hi;
    logic    m_lo;
    logic    m_zero;
    logic    r_zero;
  } dp_st_t;

endpackage

FILE: rtl/pfn_datapath.sv
// datapath: vertex registers, cross-product sums, normalize, square root and divide
module pfn_datapath #(
  parameter int MAX_VERTICES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pfn_pkg::cmd_t    cmd,
  output pfn_pkg::dp_st_t  st,
  input  logic [55:0]      in_tdata,
  input  logic             in_tlast,
  output logic [47:0]      out_tdata,
  output logic [1:0]       out_tuser
);
  import pfn_pkg::*;

  logic signed [15:0] cur_x_r, cur_y_r, cur_z_r;
  logic               present_r, last_r;
  logic signed [15:0] first_x_r, first_y_r, first_z_r;
  logic signed [15:0] prev_x_r, prev_y_r, prev_z_r;
  logic [6:0]         cnt_r;
  logic signed [39:0] sum_x_r, sum_y_r, sum_z_r;
  status_t            err_r;
  logic [39:0]        m0_r, m1_r, m2_r;
  logic               sg0_r, sg1_r, sg2_r;
  logic [49:0]        q_r;
  logic [63:0]        v_r, res_r;
  logic [45:0]        rem_r;
  logic [14:0]        quo_r;
  logic signed [15:0] n_x_r, n_y_r, n_z_r;
  logic [47:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  logic signed [16:0] ax, ay, az, bx, by, bz, ma, mb;
  logic signed [33:0] prod;
  logic signed [39:0] pext, sum_sel, sum_new;
  logic               neg;
  logic [23:0]        msel;
  logic [47:0]        sq;
  logic [63:0]        bitv, trial;
  logic [45:0]        dvs;
  logic [14:0]        capped;
  logic               sgsel;
  logic signed [15:0] nval;

  assign ax = 17'(cur_x_r) - 17'(prev_x_r);
  assign ay = 17'(cur_y_r) - 17'(prev_y_r);
  assign az = 17'(cur_z_r) - 17'(prev_z_r);
  assign bx = 17'(first_x_r) - 17'(prev_x_r);
  assign by = 17'(first_y_r) - 17'(prev_y_r);
  assign bz = 17'(first_z_r) - 17'(prev_z_r);

  always_comb begin
    ma = ay; mb = bz; neg = 1'b0; sum_sel = sum_x_r;
    case (cmd.idx[2:0])
      3'd0: begin ma = ay; mb = bz; neg = 1'b0; sum_sel = sum_x_r; end
      3'd1: begin ma = az; mb = by; neg = 1'b1; sum_sel = sum_x_r; end
      3'd2: begin ma = az; mb = bx; neg = 1'b0; sum_sel = sum_y_r; end
      3'd3: begin ma = ax; mb = bz; neg = 1'b1; sum_sel = sum_y_r; end
      3'd4: begin ma = ax; mb = by; neg = 1'b0; sum_sel = sum_z_r; end
      3'd5: begin ma = ay; mb = bx; neg = 1'b1; sum_sel = sum_z_r; end
      default: begin ma = ay; mb = bz; neg = 1'b0; sum_sel = sum_x_r; end
    endcase
  end

  assign prod    = ma * mb;
  assign pext    = {{6{prod[33]}}, prod};
  assign sum_new = neg ? (sum_sel - pext) : (sum_sel + pext);

  always_comb begin
    case (cmd.comp)
      2'd0:    begin msel = m0_r[23:0]; sgsel = sg0_r; end
      2'd1:    begin msel = m1_r[23:0]; sgsel = sg1_r; end
      default: begin msel = m2_r[23:0]; sgsel = sg2_r; end
    endcase
  end

  assign sq     = msel * msel;
  assign bitv   = 64'(1) << {cmd.idx, 1'b0};
  assign trial  = res_r + bitv;
  assign dvs    = 46'(res_r[31:0]) << cmd.idx[3:0];
  assign capped = (quo_r > 15'd16384) ? 15'd16384 : quo_r;
  assign nval   = sgsel ? -16'(capped) : 16'(capped);

  assign st.take   = (err_r == ST_OK) && (cnt_r < 7'(MAX_VERTICES)) && present_r;
  assign st.ge2    = cnt_r >= 7'd2;
  assign st.last   = last_r;
  assign st.err    = err_r;
  assign st.m_hi   = |{m0_r[39:24], m1_r[39:24], m2_r[39:24]};
  assign st.m_lo   = ~|{m0_r[39:23], m1_r[39:23], m2_r[39:23]};
  assign st.m_zero = ~|{m0_r, m1_r, m2_r};
  assign st.r_zero = res_r == 64'd0;

  // polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0; first_y_r <= '0; first_z_r <= '0;
      prev_x_r  <= '0; prev_y_r  <= '0; prev_z_r  <= '0;
      cnt_r     <= '0;
      sum_x_r   <= '0; sum_y_r   <= '0; sum_z_r   <= '0;
      err_r     <= ST_OK;
    end else begin
      case (cmd.op)
        OP_MAC: begin
          case (cmd.idx[2:0]) inside
            3'd0, 3'd1: sum_x_r <= sum_new;
            3'd2, 3'd3: sum_y_r <= sum_new;
            default:    sum_z_r <= sum_new;
          endcase
        end
        OP_CHECK: begin
          if (err_r == ST_OK) begin
            if (cnt_r >= 7'(MAX_VERTICES)) begin
              err_r <= ST_TOOMANY;
            end else if (!present_r) begin
              err_r <= ST_MISSING;
            end else begin
              if (cnt_r == 7'd0) begin
                first_x_r <= cur_x_r; first_y_r <= cur_y_r; first_z_r <= cur_z_r;
              end
              prev_x_r <= cur_x_r; prev_y_r <= cur_y_r; prev_z_r <= cur_z_r;
              cnt_r    <= cnt_r + 7'd1;
            end
          end
        end
        OP_EMIT: begin
          first_x_r <= '0; first_y_r <= '0; first_z_r <= '0;
          prev_x_r  <= '0; prev_y_r  <= '0; prev_z_r  <= '0;
          cnt_r     <= '0;
          sum_x_r   <= '0; sum_y_r   <= '0; sum_z_r   <= '0;
          err_r     <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cur_x_r   <= in_tdata[15:0];
        cur_y_r   <= in_tdata[31:16];
        cur_z_r   <= in_tdata[47:32];
        present_r <= in_tdata[48];
        last_r    <= in_tlast;
      end
      OP_ABS: begin
        m0_r  <= sum_x_r[39] ? 40'(-sum_x_r) : 40'(sum_x_r);
        m1_r  <= sum_y_r[39] ? 40'(-sum_y_r) : 40'(sum_y_r);
        m2_r  <= sum_z_r[39] ? 40'(-sum_z_r) : 40'(sum_z_r);
        sg0_r <= sum_x_r[39];
        sg1_r <= sum_y_r[39];
        sg2_r <= sum_z_r[39];
      end
      OP_SHIFT: begin
        if (st.m_hi) begin
          m0_r <= m0_r >> 1; m1_r <= m1_r >> 1; m2_r <= m2_r >> 1;
        end else begin
          m0_r <= m0_r << 1; m1_r <= m1_r << 1; m2_r <= m2_r << 1;
        end
      end
      OP_SQ: q_r <= ((cmd.comp == 2'd0) ? 50'd0 : q_r) + 50'(sq);
      OP_SQRT_INIT: begin
        v_r   <= {2'b00, q_r, 12'd0};
        res_r <= '0;
      end
      OP_SQRT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      OP_DIV_INIT: begin
        rem_r <= (46'(msel) << 20) + 46'(res_r[31:1]);
        quo_r <= '0;
      end
      OP_DIV: begin
        if (rem_r >= dvs) begin
          rem_r             <= rem_r - dvs;
          quo_r[cmd.idx[3:0]] <= 1'b1;
        end
      end
      OP_DIV_END: begin
        case (cmd.comp)
          2'd0:    n_x_r <= nval;
          2'd1:    n_y_r <= nval;
          default: n_z_r <= nval;
        endcase
      end
      OP_EMIT: begin
        out_tdata_r <= (cmd.stat == ST_OK) ? {n_z_r, n_y_r, n_x_r} : 48'd0;
        out_tuser_r <= cmd.stat;
      end
      default: ;
    endcase
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

FILE: rtl/pfn_ctrl.sv
// controller: sequences vertex accumulation and the normalize steps
module pfn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  pfn_pkg::dp_st_t  st,
  output pfn_pkg::cmd_t    cmd
);
  import pfn_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_EVAL   = 15'b000000000000010,
    S_MAC    = 15'b000000000000100,
    S_CHECK  = 15'b000000000001000,
    S_DECIDE = 15'b000000000010000,
    S_ZCHK   = 15'b000000000100000,
    S_SHIFT  = 15'b000000001000000,
    S_SQ     = 15'b000000010000000,
    S_SQRTI  = 15'b000000100000000,
    S_SQRT   = 15'b000001000000000,
    S_RCHK   = 15'b000010000000000,
    S_DIVI   = 15'b000100000000000,
    S_DIVS   = 15'b001000000000000,
    S_DIVE   = 15'b010000000000000,
    S_EMIT   = 15'b100000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [1:0] comp_r, comp_nxt;
  status_t    stat_r, stat_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    comp_nxt   = comp_r;
    stat_nxt   = stat_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd.op     = OP_NONE;
    cmd.idx    = idx_r;
    cmd.comp   = comp_r;
    cmd.stat   = stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        idx_nxt   = 5'd0;
        state_nxt = (st.take && st.ge2) ? S_MAC : S_CHECK;
      end
      S_MAC: begin
        cmd.op  = OP_MAC;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd5) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (st.err != ST_OK) begin
          stat_nxt  = st.err;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_ABS;
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (st.m_zero) begin
          stat_nxt  = ST_ZERO;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st.m_hi || st.m_lo) begin
          cmd.op = OP_SHIFT;
        end else begin
          comp_nxt  = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op   = OP_SQ;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd2) state_nxt = S_SQRTI;
      end
      S_SQRTI: begin
        cmd.op    = OP_SQRT_INIT;
        idx_nxt   = 5'd30;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        idx_nxt = idx_r - 5'd1;
        if (idx_r == 5'd0) state_nxt = S_RCHK;
      end
      S_RCHK: begin
        comp_nxt = 2'd0;
        if (st.r_zero) begin
          stat_nxt  = ST_ZERO;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_INIT;
        idx_nxt   = 5'd14;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op  = OP_DIV;
        idx_nxt = idx_r - 5'd1;
        if (idx_r == 5'd0) state_nxt = S_DIVE;
      end
      S_DIVE: begin
        cmd.op   = OP_DIV_END;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd2) begin
          stat_nxt  = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIVI;
        end
      end
      S_EMIT: begin
        if (!(ovalid_r && !out_tready)) begin
          cmd.op     = OP_EMIT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      comp_r   <= '0;
      stat_r   <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      comp_r   <= comp_nxt;
      stat_r   <= stat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

FILE: rtl/polygon_face_normal.sv
// top level of the polygon face normal block
//
// usage: vertices of one polygon enter on the in_ stream, one item per
// vertex, tlast on the final vertex. in_tdata carries x, y, z (signed Q8.8)
// and the position present flag. one result item leaves on the out_ stream
// per polygon: the unit normal in Q1.14 in out_tdata, the status in out_tuser.
// a vertex that is rejected or is one of the first two goes straight to the
// check; one that adds a fan cross product first runs the six products on
// one shared 17x17 multiplier, one per cycle.
// the last vertex adds the normalize sequence: shift steps, the three
// squares on one 24x24 multiplier, the bit-serial root, and the restoring
// divider for each of the three components.
// in_tready is high only between items. a result waits in the output
// register while the receiver stalls; the next polygon's vertices are taken
// meanwhile, and only the next result waits for the register to empty.
// reset clears the polygon state and drops out_tvalid.
module polygon_face_normal #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // x_coord, y_coord, z_coord, position_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_x, normal_y, normal_z
  output logic [1:0]  out_tuser   // status
);
  import pfn_pkg::*;

  cmd_t   cmd;
  dp_st_t st;

  pfn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  pfn_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: rtl/pfn_checker.sv
// port checker for the polygon face normal block and its bind
module pfn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import pfn_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 48'd0)
    else $error("nonzero normal with error status");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |->
      $signed(out_tdata[15:0]) >= -16'sd16384 && $signed(out_tdata[15:0]) <= 16'sd16384 &&
      $signed(out_tdata[31:16]) >= -16'sd16384 && $signed(out_tdata[31:16]) <= 16'sd16384 &&
      $signed(out_tdata[47:32]) >= -16'sd16384 && $signed(out_tdata[47:32]) <= 16'sd16384)
    else $error("normal component out of range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

endmodule

bind polygon_face_normal pfn_checker u_chk (.*);

FILE: verif/tb_polygon_face_normal.sv
// testbench for the polygon face normal block: vertex streams against a built-in normal predictor
module tb_polygon_face_normal;
  import pfn_pkg::*;

  localparam int MAXV = 16;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    status_t            st;
  } normal_t;

  normal_t normals_due[$];

  logic signed [15:0] first_v [3];
  logic signed [15:0] prev_v [3];
  int unsigned        vcount;
  logic signed [39:0] acc [3];
  status_t            err_st;
  logic               err_flag;

  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  in_stall = 1'b0;
  int  out_burst = 0;
  bit  done = 1'b0;

  polygon_face_normal #(.MAX_VERTICES(MAXV)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv, x;
    res = 0;
    x = v;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal();
    normal_t r;
    logic [63:0] m [3];
    logic [63:0] mx, q, rt, v;
    r.nx = 0; r.ny = 0; r.nz = 0; r.st = ST_ZERO;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = acc[i] < 0 ? 64'(-$signed(64'(acc[i]))) : 64'(acc[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return r;
    while (mx >= (64'd1 << 24)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 23)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    q = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    rt = isqrt(q << 12);
    if (rt == 0) return r;
    r.st = ST_OK;
    for (int i = 0; i < 3; i++) begin
      v = ((m[i] << 20) + (rt >> 1)) / rt;
      if (v > 16384) v = 16384;
      if (acc[i] < 0) v = -v;
      if (i == 0) r.nx = v[15:0];
      else if (i == 1) r.ny = v[15:0];
      else r.nz = v[15:0];
    end
    return r;
  endfunction

  task automatic clear_polygon();
    for (int i = 0; i < 3; i++) begin
      first_v[i] = 0; prev_v[i] = 0; acc[i] = 0;
    end
    vcount = 0;
    err_flag = 1'b0;
    err_st = ST_OK;
  endtask

  task automatic predict_vertex(input logic signed [15:0] c [3], input bit present, input bit last);
    logic signed [39:0] a [3], b [3];
    normal_t r;
    if (!err_flag) begin
      if (vcount >= MAXV) begin
        err_flag = 1'b1; err_st = ST_TOOMANY;
      end else if (!present) begin
        err_flag = 1'b1; err_st = ST_MISSING;
      end else begin
        if (vcount == 0) first_v = c;
        if (vcount >= 2) begin
          for (int i = 0; i < 3; i++) begin
            a[i] = 40'(c[i]) - 40'(prev_v[i]);
            b[i] = 40'(first_v[i]) - 40'(prev_v[i]);
          end
          acc[0] = acc[0] + (a[1] * b[2] - a[2] * b[1]);
          acc[1] = acc[1] + (a[2] * b[0] - a[0] * b[2]);
          acc[2] = acc[2] + (a[0] * b[1] - a[1] * b[0]);
        end
        prev_v = c;
        vcount++;
      end
    end
    if (last) begin
      if (err_flag) begin
        r.nx = 0; r.ny = 0; r.nz = 0; r.st = err_st;
      end else begin
        r = unit_normal();
      end
      normals_due.push_back(r);
      clear_polygon();
    end
  endtask

  task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input bit present, input bit last);
    logic signed [15:0] c [3];
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    c[0] = x; c[1] = y; c[2] = z;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, present, z, y, x};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_vertex(c, present, last);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_burst > 0) begin
        out_burst <= out_burst - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_burst <= $urandom_range(1, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    normal_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (normals_due.size() == 0) begin
        report_mismatch("unexpected item status", out_tuser, -1);
      end else begin
        w = normals_due.pop_front();
        if ($signed(out_tdata[15:0]) != w.nx)
          report_mismatch("normal_x", $signed(out_tdata[15:0]), w.nx);
        if ($signed(out_tdata[31:16]) != w.ny)
          report_mismatch("normal_y", $signed(out_tdata[31:16]), w.ny);
        if ($signed(out_tdata[47:32]) != w.nz)
          report_mismatch("normal_z", $signed(out_tdata[47:32]), w.nz);
        if (out_tuser != w.st) report_mismatch("status", out_tuser, w.st);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] rnd_coord(input bit wide);
    if (wide) return 16'($urandom());
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
    endcase
  endfunction

  task automatic send_polygon(input int n, input bit wide, input int hole);
    for (int i = 0; i < n; i++)
      send_vertex(rnd_coord(wide), rnd_coord(wide), rnd_coord(wide), i != hole, i == n - 1);
  endtask

  task automatic test_directed();
    send_vertex(0, 0, 0, 1, 0);
    send_vertex(16'sd256, 0, 0, 1, 0);
    send_vertex(0, 16'sd256, 0, 1, 1);
    send_vertex(0, 0, 0, 1, 0);
    send_vertex(0, 16'sd256, 0, 1, 0);
    send_vertex(16'sd256, 0, 0, 1, 1);
    send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1, 0);
    send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1, 0);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh8000, 1, 1);
    send_vertex(16'sd5, 16'sd5, 16'sd5, 1, 1);
    send_vertex(16'sd5, 16'sd5, 16'sd5, 1, 0);
    send_vertex(16'sd9, 16'sd9, 16'sd9, 1, 1);
    send_vertex(1, 2, 3, 1, 0);
    send_vertex(1, 2, 3, 0, 0);
    send_vertex(4, 5, 6, 1, 1);
    send_vertex(0, 0, 0, 0, 1);
    send_vertex(1, 0, 0, 1, 0);
    send_vertex(2, 0, 0, 1, 0);
    send_vertex(3, 0, 0, 1, 1);
  endtask

  task automatic test_vertex_limit();
    send_polygon(MAXV, 1'b0, -1);
    send_polygon(MAXV + 1, 1'b0, -1);
    send_polygon(MAXV + 3, 1'b1, -1);
  endtask

  task automatic test_random(input int count);
    int sent, n, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) n = $urandom_range(3, 8);
      else if (pick < 17) n = $urandom_range(1, 2);
      else n = $urandom_range(9, MAXV + 2);
      send_polygon(n, $urandom_range(0, 1), pick == 19 ? $urandom_range(0, n - 1) : -1);
      sent += n;
    end
  endtask

  task automatic drain();
    while (normals_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clear_polygon();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_vertex_limit();
    test_random(450);
    drain();
    test_random(300);
    quiet = 1'b1;
    test_random(150);
    drain();
    repeat (200) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && normals_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
